// ===== sv/stp_pkg.sv =====
package stp_pkg;

   localparam int TEXT_W = 8;
   localparam int LEN_W = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W = 5;
   localparam int YEAR_W = 12;
   localparam int HOUR_W = 5;
   localparam int MIN_W = 6;
   localparam int SEC_W = 6;
   localparam int ACC_W = 12;
   localparam int CODE_W = 4;

   localparam int DEFAULT_MAX_CONSUMED = 4095;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam int ACC_MAX = 4095;
   localparam int YEAR_LO = 1970;
   localparam int YEAR_HI = 2100;
   localparam int DAY_MAX = 31;
   localparam int HOUR_MAX = 23;
   localparam int MIN_MAX = 59;
   localparam int SEC_MAX = 60;

   localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
   localparam logic [TEXT_W-1:0] CH_COLON = 8'h3a;
   localparam logic [TEXT_W-1:0] CH_ZERO = 8'h30;
   localparam logic [TEXT_W-1:0] CH_NINE = 8'h39;
   localparam logic [TEXT_W-1:0] CASE_BIT = 8'h20;

   // one byte after classification
   typedef struct packed {
      logic                last;
      logic                is_digit;
      logic [3:0]          digit;
      logic                is_space;
      logic                is_colon;
      logic [CODE_W-1:0]   first_code;
      logic [TEXT_W-1:0]   lower;
   } stp_class_type;

   typedef struct packed {
      logic                matched;
      logic [LEN_W-1:0]    consumed_len;
      logic [MONTH_W-1:0]  month_num;
      logic [DAY_W-1:0]    day_num;
      logic [YEAR_W-1:0]   year_num;
      logic [HOUR_W-1:0]   hour_num;
      logic [MIN_W-1:0]    minute_num;
      logic [SEC_W-1:0]    second_num;
   } stp_result_type;

   // month name, first letter: 0 when no month starts with it
   function automatic logic [CODE_W-1:0] first_code(input logic [TEXT_W-1:0] lower);
      logic [CODE_W-1:0] code;
      unique case (lower)
         "j": code = 4'd1;
         "f": code = 4'd2;
         "m": code = 4'd3;
         "a": code = 4'd4;
         "s": code = 4'd5;
         "o": code = 4'd6;
         "n": code = 4'd7;
         "d": code = 4'd8;
         default: code = 4'd0;
      endcase
      return code;
   endfunction

   // two-letter prefix code from first-letter code and second letter
   function automatic logic [CODE_W-1:0] pair_code(input logic [CODE_W-1:0] prefix,
                                                   input logic [TEXT_W-1:0] lower);
      logic [CODE_W-1:0] code;
      unique case ({prefix, lower})
         {4'd1, "a"}: code = 4'd1;
         {4'd1, "u"}: code = 4'd2;
         {4'd2, "e"}: code = 4'd3;
         {4'd3, "a"}: code = 4'd4;
         {4'd4, "p"}: code = 4'd5;
         {4'd4, "u"}: code = 4'd6;
         {4'd5, "e"}: code = 4'd7;
         {4'd6, "c"}: code = 4'd8;
         {4'd7, "o"}: code = 4'd9;
         {4'd8, "e"}: code = 4'd10;
         default: code = 4'd0;
      endcase
      return code;
   endfunction

   // month number from two-letter code and third letter
   function automatic logic [MONTH_W-1:0] tri_month(input logic [CODE_W-1:0] prefix,
                                                    input logic [TEXT_W-1:0] lower);
      logic [MONTH_W-1:0] month;
      unique case ({prefix, lower})
         {4'd1, "n"}: month = 4'd1;
         {4'd2, "n"}: month = 4'd6;
         {4'd2, "l"}: month = 4'd7;
         {4'd3, "b"}: month = 4'd2;
         {4'd4, "r"}: month = 4'd3;
         {4'd4, "y"}: month = 4'd5;
         {4'd5, "r"}: month = 4'd4;
         {4'd6, "g"}: month = 4'd8;
         {4'd7, "p"}: month = 4'd9;
         {4'd8, "t"}: month = 4'd10;
         {4'd9, "v"}: month = 4'd11;
         {4'd10, "c"}: month = 4'd12;
         default: month = 4'd0;
      endcase
      return month;
   endfunction

endpackage

// ===== sv/stp_if.sv =====
interface stp_req_if import stp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] text_byte;
   logic              last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface stp_rsp_if import stp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               matched;
   logic [LEN_W-1:0]   consumed_len;
   logic [MONTH_W-1:0] month_num;
   logic [DAY_W-1:0]   day_num;
   logic [YEAR_W-1:0]  year_num;
   logic [HOUR_W-1:0]  hour_num;
   logic [MIN_W-1:0]   minute_num;
   logic [SEC_W-1:0]   second_num;

   modport source (output valid, output matched, output consumed_len, output month_num,
                   output day_num, output year_num, output hour_num, output minute_num,
                   output second_num, input ready);
   modport sink (input valid, input matched, input consumed_len, input month_num,
                 input day_num, input year_num, input hour_num, input minute_num,
                 input second_num, output ready);
endinterface

// ===== sv/stp_front.sv =====
module stp_front import stp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   stp_req_if.sink       req_if,
   output logic          push_valid,
   output stp_class_type push_item,
   input  logic          push_ready
);

   logic          valid_ff;
   logic          valid_in;
   stp_class_type item_ff;
   stp_class_type item_in;
   logic [TEXT_W-1:0] lower;

   assign req_if.ready = !valid_ff || push_ready;
   assign lower = req_if.text_byte | CASE_BIT;

   always_comb begin
      item_in.last = req_if.last_byte;
      item_in.is_digit = (req_if.text_byte >= CH_ZERO) && (req_if.text_byte <= CH_NINE);
      // low nibble of an ascii digit is its value
      item_in.digit = req_if.text_byte[3:0];
      item_in.is_space = (req_if.text_byte == CH_SPACE);
      item_in.is_colon = (req_if.text_byte == CH_COLON);
      item_in.first_code = first_code(lower);
      item_in.lower = lower;
   end

   assign valid_in = (req_if.valid && req_if.ready) || (valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         item_ff <= item_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item = item_ff;

endmodule

// ===== sv/stp_queue.sv =====
module stp_queue import stp_pkg::*; #(
   parameter int WIDTH = $bits(stp_class_type),
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill beyond depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("queue fill did not follow a lone write");

endmodule

// ===== sv/stp_back.sv =====
module stp_back import stp_pkg::*; #(
   parameter int MAX_CONSUMED = DEFAULT_MAX_CONSUMED
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  stp_class_type q_item,
   output logic          q_pop,
   stp_rsp_if.source     rsp_if
);

   localparam int CNT_W = $clog2(MAX_CONSUMED + 1);

   typedef enum logic [3:0] {
      PH_M1, PH_M2, PH_M3, PH_SP, PH_DAYSTART, PH_DAY, PH_HOUR1, PH_HOUR2, PH_MIN, PH_SEC
   } phase_type;

   phase_type          phase_ff, phase_in, end_phase;
   logic [ACC_W-1:0]   accum_ff, accum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CODE_W-1:0]  prefix_ff, prefix_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [HOUR_W-1:0]  hour_ff, hour_in;
   logic [MIN_W-1:0]   minute_ff, minute_in;
   logic [SEC_W-1:0]   second_ff, second_in;
   logic               done_ff, done_in;
   logic               fail_ff, fail_in;
   logic               rsp_valid_ff, rsp_valid_in;
   stp_result_type     rsp_ff, rsp_in;

   logic               take;
   logic               digit_path;
   logic               run_end;
   logic               fin_ok;
   logic [15:0]        acc_wide;
   logic [ACC_W-1:0]   acc_next;
   logic [CODE_W-1:0]  pair;
   logic [MONTH_W-1:0] month_hit;
   logic               is_year;

   assign q_pop = q_valid && (!q_item.last || !rsp_valid_ff || rsp_if.ready);

   // accum * 10 + digit, held at the run ceiling
   assign acc_wide = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1) + {12'd0, q_item.digit};
   assign acc_next = (acc_wide > 16'(ACC_MAX)) ? ACC_W'(ACC_MAX) : acc_wide[ACC_W-1:0];
   assign pair = pair_code(prefix_ff, q_item.lower);
   assign month_hit = tri_month(prefix_ff, q_item.lower);
   assign is_year = (accum_ff > ACC_W'(YEAR_LO)) && (accum_ff < ACC_W'(YEAR_HI));

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      prefix_in = prefix_ff;
      month_in = month_ff;
      day_in = day_ff;
      year_in = year_ff;
      hour_in = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      done_in = done_ff;
      fail_in = fail_ff;
      take = 1'b0;
      digit_path = 1'b0;
      run_end = 1'b0;
      end_phase = phase_ff;
      fin_ok = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in = rsp_ff;

      if (q_pop && !done_ff && !fail_ff) begin
         unique case (phase_ff)
            PH_M1: begin
               if (q_item.first_code == '0) begin
                  fail_in = 1'b1;
               end else begin
                  prefix_in = q_item.first_code;
                  take = 1'b1;
                  phase_in = PH_M2;
               end
            end
            PH_M2: begin
               if (pair == '0) begin
                  fail_in = 1'b1;
               end else begin
                  prefix_in = pair;
                  take = 1'b1;
                  phase_in = PH_M3;
               end
            end
            PH_M3: begin
               if (month_hit == '0) begin
                  fail_in = 1'b1;
               end else begin
                  month_in = month_hit;
                  take = 1'b1;
                  phase_in = PH_SP;
               end
            end
            PH_SP: begin
               if (!q_item.is_space) begin
                  fail_in = 1'b1;
               end else begin
                  take = 1'b1;
                  accum_in = '0;
                  phase_in = PH_DAYSTART;
               end
            end
            PH_DAYSTART: begin
               // one extra space before the day
               if (q_item.is_space) begin
                  take = 1'b1;
                  accum_in = '0;
                  phase_in = PH_DAY;
               end else begin
                  phase_in = PH_DAY;
                  end_phase = PH_DAY;
                  digit_path = 1'b1;
               end
            end
            default: digit_path = 1'b1;
         endcase

         if (digit_path) begin
            if (q_item.is_digit) begin
               accum_in = acc_next;
               take = 1'b1;
            end else begin
               run_end = 1'b1;
            end
         end

         if (run_end) begin
            unique case (end_phase)
               PH_DAY: begin
                  if (accum_ff == '0 || accum_ff > ACC_W'(DAY_MAX) || !q_item.is_space) begin
                     fail_in = 1'b1;
                  end else begin
                     day_in = accum_ff[DAY_W-1:0];
                     take = 1'b1;
                     accum_in = '0;
                     phase_in = PH_HOUR1;
                  end
               end
               PH_HOUR1, PH_HOUR2: begin
                  if (end_phase == PH_HOUR1 && is_year) begin
                     if (!q_item.is_space) begin
                        fail_in = 1'b1;
                     end else begin
                        year_in = accum_ff[YEAR_W-1:0];
                        take = 1'b1;
                        accum_in = '0;
                        phase_in = PH_HOUR2;
                     end
                  end else if (accum_ff > ACC_W'(HOUR_MAX) || !q_item.is_colon) begin
                     fail_in = 1'b1;
                  end else begin
                     hour_in = accum_ff[HOUR_W-1:0];
                     take = 1'b1;
                     accum_in = '0;
                     phase_in = PH_MIN;
                  end
               end
               PH_MIN: begin
                  if (accum_ff > ACC_W'(MIN_MAX) || !q_item.is_colon) begin
                     fail_in = 1'b1;
                  end else begin
                     minute_in = accum_ff[MIN_W-1:0];
                     take = 1'b1;
                     accum_in = '0;
                     phase_in = PH_SEC;
                  end
               end
               PH_SEC: begin
                  if (accum_ff > ACC_W'(SEC_MAX)) begin
                     fail_in = 1'b1;
                  end else begin
                     second_in = accum_ff[SEC_W-1:0];
                     // a trailing colon belongs to the timestamp
                     take = q_item.is_colon;
                     done_in = 1'b1;
                  end
               end
               default: fail_in = 1'b1;
            endcase
         end

         if (take && count_ff < CNT_W'(MAX_CONSUMED)) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (q_pop && q_item.last) begin
         // string ended: an outcome stands; with none, only a seconds run can close it
         if (done_in || fail_in) begin
            fin_ok = done_in;
         end else if (phase_in == PH_SEC && accum_in <= ACC_W'(SEC_MAX)) begin
            fin_ok = 1'b1;
            second_in = accum_in[SEC_W-1:0];
         end
         rsp_valid_in = 1'b1;
         rsp_in.matched = fin_ok;
         rsp_in.consumed_len = fin_ok ? LEN_W'(count_in) : '0;
         rsp_in.month_num = fin_ok ? month_in : '0;
         rsp_in.day_num = fin_ok ? day_in : '0;
         rsp_in.year_num = fin_ok ? year_in : '0;
         rsp_in.hour_num = fin_ok ? hour_in : '0;
         rsp_in.minute_num = fin_ok ? minute_in : '0;
         rsp_in.second_num = fin_ok ? second_in : '0;

         phase_in = PH_M1;
         accum_in = '0;
         count_in = '0;
         prefix_in = '0;
         month_in = '0;
         day_in = '0;
         year_in = '0;
         hour_in = '0;
         minute_in = '0;
         second_in = '0;
         done_in = 1'b0;
         fail_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         phase_ff <= PH_M1;
         accum_ff <= '0;
         count_ff <= '0;
         prefix_ff <= '0;
         month_ff <= '0;
         day_ff <= '0;
         year_ff <= '0;
         hour_ff <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         done_ff <= 1'b0;
         fail_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         prefix_ff <= prefix_in;
         month_ff <= month_in;
         day_ff <= day_in;
         year_ff <= year_in;
         hour_ff <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         done_ff <= done_in;
         fail_ff <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.matched = rsp_ff.matched;
   assign rsp_if.consumed_len = rsp_ff.consumed_len;
   assign rsp_if.month_num = rsp_ff.month_num;
   assign rsp_if.day_num = rsp_ff.day_num;
   assign rsp_if.year_num = rsp_ff.year_num;
   assign rsp_if.hour_num = rsp_ff.hour_num;
   assign rsp_if.minute_num = rsp_ff.minute_num;
   assign rsp_if.second_num = rsp_ff.second_num;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(q_pop && q_item.last))
      else $error("result raised without a final byte");

   a_match_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.matched |->
         rsp_ff.month_num != '0 && rsp_ff.month_num <= MONTH_W'(12) &&
         rsp_ff.day_num != '0)
      else $error("matched result without month or day");

   a_done_fail_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && fail_ff))
      else $error("parse both done and failed");

endmodule

// ===== sv/syslog_timestamp_parser_unit.sv =====
// Syslog timestamp parser: takes one text byte per cycle, from the first byte of a
// "Mmm dd [yyyy ]hh:mm:ss[:]" timestamp on, with last_byte set on the final byte of
// the string. Exactly one result comes back for each final byte: matched, consumed
// length and the parsed fields, all zero when no timestamp was recognised. Bytes are
// taken at one per cycle for as long as results are taken; a stalled result holds
// back the next final byte and the bytes behind it, while bytes ahead of it keep
// flowing into the parser. A final byte passes the classifying input register and
// the queue, after which the parser loads its result into its result register, from
// which it can be taken. The parser updates its state from each byte as it pops it,
// which sets the rate of one byte per cycle.
module syslog_timestamp_parser_unit import stp_pkg::*; #(
   parameter int MAX_CONSUMED = DEFAULT_MAX_CONSUMED,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   stp_req_if.sink    req_if,
   stp_rsp_if.source  rsp_if
);

   localparam int ITEM_W = $bits(stp_class_type);

   logic          push_valid;
   logic          push_ready;
   stp_class_type push_item;
   logic          q_valid;
   logic          q_pop;
   logic [ITEM_W-1:0] q_data;
   stp_class_type q_item;

   stp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   stp_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_item),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop        (q_pop)
   );

   assign q_item = stp_class_type'(q_data);

   stp_back #(
      .MAX_CONSUMED (MAX_CONSUMED)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

// ===== dv/tb_syslog_timestamp_parser_unit.sv =====
module tb_syslog_timestamp_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import stp_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_BYTES = 540;
   localparam int RANDOM_RESULTS = 25;
   localparam int DRAIN_CYCLES = 12;

   typedef logic [TEXT_W-1:0] byte_queue_type [$];

   typedef enum logic [3:0] {
      TS_MON1, TS_MON2, TS_MON3, TS_MON_SPACE, TS_DAY_START, TS_DAY_DIGITS,
      TS_HOUR_OR_YEAR, TS_HOUR_AFTER_YEAR, TS_MINUTE, TS_SECOND
   } ts_phase_type;

   typedef enum logic [1:0] {TS_OPEN, TS_DONE, TS_FAIL} ts_outcome_type;

   localparam stp_result_type NO_MATCH = '0;

   logic clock = 1'b0;
   logic reset;

   stp_req_if req_bus ();
   stp_rsp_if rsp_bus ();

   syslog_timestamp_parser_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #4 clock = ~clock;

   // timestamp predictor state
   ts_phase_type   ts_phase;
   ts_outcome_type ts_outcome;
   int          ts_acc;
   int          ts_used;
   int          ts_month;
   int          ts_day;
   int          ts_year;
   int          ts_hour;
   int          ts_minute;
   int          ts_second;
   logic [7:0]  ts_letters [3];

   string month_names [12] = '{"jan", "feb", "mar", "apr", "may", "jun",
                               "jul", "aug", "sep", "oct", "nov", "dec"};

   stp_result_type timestamps_due [$];
   string          dir_text [$];
   bit             dir_typed [$];
   stp_result_type dir_want [$];

   bit steady;
   int errors;
   int cycles;
   int bytes_sent;
   int strings_sent;
   int results_seen;
   int matches_seen;

   function automatic void clear_parser();
      ts_phase = TS_MON1;
      ts_outcome = TS_OPEN;
      ts_acc = 0;
      ts_used = 0;
      ts_month = 0;
      ts_day = 0;
      ts_year = 0;
      ts_hour = 0;
      ts_minute = 0;
      ts_second = 0;
   endfunction

   function automatic void take_byte();
      if (ts_used < DEFAULT_MAX_CONSUMED) ts_used++;
   endfunction

   function automatic void start_run(input ts_phase_type ph);
      ts_phase = ph;
      ts_acc = 0;
   endfunction

   // month number whose first n letters agree with those held, 0 if none
   function automatic int month_match(input int n);
      bit hit;
      for (int m = 0; m < 12; m++) begin
         hit = 1'b1;
         for (int k = 0; k < n; k++)
            if (month_names[m][k] != ts_letters[k]) hit = 1'b0;
         if (hit) return m + 1;
      end
      return 0;
   endfunction

   // a digit run has ended on byte c, or on the end of the string
   function automatic void close_run(input logic [7:0] c, input bit at_end);
      if (ts_phase == TS_HOUR_OR_YEAR && ts_acc > YEAR_LO && ts_acc < YEAR_HI) begin
         if (at_end || c != CH_SPACE) begin
            ts_outcome = TS_FAIL;
            return;
         end
         ts_year = ts_acc;
         take_byte();
         start_run(TS_HOUR_AFTER_YEAR);
         return;
      end
      case (ts_phase)
         TS_DAY_START, TS_DAY_DIGITS: begin
            if (ts_acc < 1 || ts_acc > DAY_MAX || at_end || c != CH_SPACE) begin
               ts_outcome = TS_FAIL;
               return;
            end
            ts_day = ts_acc;
            take_byte();
            start_run(TS_HOUR_OR_YEAR);
         end
         TS_HOUR_OR_YEAR, TS_HOUR_AFTER_YEAR: begin
            if (ts_acc > HOUR_MAX || at_end || c != CH_COLON) begin
               ts_outcome = TS_FAIL;
               return;
            end
            ts_hour = ts_acc;
            take_byte();
            start_run(TS_MINUTE);
         end
         TS_MINUTE: begin
            if (ts_acc > MIN_MAX || at_end || c != CH_COLON) begin
               ts_outcome = TS_FAIL;
               return;
            end
            ts_minute = ts_acc;
            take_byte();
            start_run(TS_SECOND);
         end
         TS_SECOND: begin
            if (ts_acc > SEC_MAX) begin
               ts_outcome = TS_FAIL;
               return;
            end
            ts_second = ts_acc;
            // one trailing colon belongs to the timestamp
            if (!at_end && c == CH_COLON) take_byte();
            ts_outcome = TS_DONE;
         end
         default: ts_outcome = TS_FAIL;
      endcase
   endfunction

   function automatic void feed_parser(input logic [7:0] c);
      logic [7:0] lc;
      int         idx;
      lc = c | CASE_BIT;
      if (ts_outcome != TS_OPEN) return;
      case (ts_phase)
         TS_MON1, TS_MON2, TS_MON3: begin
            idx = int'(ts_phase);
            ts_letters[idx] = lc;
            if (month_match(idx + 1) == 0) begin
               ts_outcome = TS_FAIL;
               return;
            end
            take_byte();
            if (ts_phase == TS_MON3) begin
               ts_month = month_match(3);
               ts_phase = TS_MON_SPACE;
            end else begin
               ts_phase = ts_phase_type'(idx + 1);
            end
            return;
         end
         TS_MON_SPACE: begin
            if (c != CH_SPACE) begin
               ts_outcome = TS_FAIL;
               return;
            end
            take_byte();
            start_run(TS_DAY_START);
            return;
         end
         TS_DAY_START: begin
            // one extra space before the day
            if (c == CH_SPACE) begin
               take_byte();
               start_run(TS_DAY_DIGITS);
               return;
            end
            ts_phase = TS_DAY_DIGITS;
         end
         default: ;
      endcase
      if (c >= CH_ZERO && c <= CH_NINE) begin
         ts_acc = ts_acc * 10 + int'(c - CH_ZERO);
         if (ts_acc > ACC_MAX) ts_acc = ACC_MAX;
         take_byte();
         return;
      end
      close_run(c, 1'b0);
   endfunction

   function automatic void predict_timestamp(input logic [7:0] c, input logic last,
                                             output bit has, output stp_result_type r);
      has = 1'b0;
      r = NO_MATCH;
      feed_parser(c);
      if (!last) return;
      if (ts_outcome == TS_OPEN) begin
         if (ts_phase >= TS_DAY_START) close_run(8'h00, 1'b1);
         else ts_outcome = TS_FAIL;
      end
      has = 1'b1;
      if (ts_outcome == TS_DONE) begin
         r.matched = 1'b1;
         r.consumed_len = LEN_W'(ts_used);
         r.month_num = MONTH_W'(ts_month);
         r.day_num = DAY_W'(ts_day);
         r.year_num = YEAR_W'(ts_year);
         r.hour_num = HOUR_W'(ts_hour);
         r.minute_num = MIN_W'(ts_minute);
         r.second_num = SEC_W'(ts_second);
      end
      clear_parser();
   endfunction

   function automatic stp_result_type stamp(input int len, input int mon, input int day,
                                            input int yr, input int hr, input int mi,
                                            input int se);
      stp_result_type r;
      r.matched = 1'b1;
      r.consumed_len = LEN_W'(len);
      r.month_num = MONTH_W'(mon);
      r.day_num = DAY_W'(day);
      r.year_num = YEAR_W'(yr);
      r.hour_num = HOUR_W'(hr);
      r.minute_num = MIN_W'(mi);
      r.second_num = SEC_W'(se);
      return r;
   endfunction

   function automatic void add_row(input string text, input bit typed,
                                   input stp_result_type want);
      dir_text.push_back(text);
      dir_typed.push_back(typed);
      dir_want.push_back(want);
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(15, 30);
   endfunction

   function automatic void put_text(ref byte_queue_type q, input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic string num_text(input int v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 7) == 0) s = {"0", s};
      return s;
   endfunction

   function automatic void time_field(ref byte_queue_type q, input int top, input int wild);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return;
      if (r < 92) put_text(q, num_text($urandom_range(0, top)));
      else put_text(q, num_text($urandom_range(top + 1, wild)));
   endfunction

   function automatic void random_string(output byte_queue_type q);
      logic [7:0] ch;
      int         m;
      int         r;
      q = {};
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      m = $urandom_range(0, 11);
      for (int k = 0; k < 3; k++) begin
         ch = month_names[m][k];
         if ($urandom_range(0, 1) == 1) ch = ch & ~CASE_BIT;
         q.push_back(ch);
      end
      q.push_back(CH_SPACE);
      if ($urandom_range(0, 3) == 0) q.push_back(CH_SPACE);
      r = $urandom_range(0, 99);
      if (r < 88) put_text(q, num_text($urandom_range(1, DAY_MAX)));
      else if (r < 92) put_text(q, "0");
      else if (r < 97) put_text(q, num_text($urandom_range(DAY_MAX + 1, 99)));
      else if (r < 99) put_text(q, num_text($urandom_range(100, 99999)));
      q.push_back(CH_SPACE);
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 7) == 0) put_text(q, $urandom_range(0, 1) ? "1970" : "2100");
         else put_text(q, num_text($urandom_range(YEAR_LO + 1, YEAR_HI - 1)));
         q.push_back(CH_SPACE);
      end
      time_field(q, HOUR_MAX, 99);
      q.push_back(CH_COLON);
      time_field(q, MIN_MAX, 99);
      q.push_back(CH_COLON);
      time_field(q, SEC_MAX, 99999);
      if ($urandom_range(0, 2) == 0) q.push_back(CH_COLON);
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(0, 3) == 0) q.push_back(8'($urandom_range(0, 255)));
         else q.push_back(8'($urandom_range(8'h20, 8'h7e)));
      end
      // broken sequences: a stray byte or a cut string
      r = $urandom_range(0, 99);
      if (r < 12) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      else if (r < 20) q = q[0:$urandom_range(0, q.size() - 1)];
   endfunction

   // valid is left high after the last byte; a gap or the caller drops it
   task automatic send_text(input byte_queue_type txt, input bit typed,
                            input stp_result_type want);
      bit             has;
      stp_result_type r;
      int             gap;
      for (int i = 0; i < txt.size(); i++) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.text_byte <= txt[i];
         req_bus.last_byte <= (i == txt.size() - 1);
         do @(posedge clock); while (!req_bus.ready);
         predict_timestamp(txt[i], i == txt.size() - 1, has, r);
         if (has) timestamps_due.push_back(typed ? want : r);
         bytes_sent++;
         @(negedge clock);
      end
      strings_sent++;
   endtask

   task automatic report_mismatch(input string field, input int got, input int want_v);
      $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want_v);
      errors++;
   endtask

   // result side: random stalls, none while steady
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
            stall_left = 0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      stp_result_type got;
      stp_result_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.matched = rsp_bus.matched;
         got.consumed_len = rsp_bus.consumed_len;
         got.month_num = rsp_bus.month_num;
         got.day_num = rsp_bus.day_num;
         got.year_num = rsp_bus.year_num;
         got.hour_num = rsp_bus.hour_num;
         got.minute_num = rsp_bus.minute_num;
         got.second_num = rsp_bus.second_num;
         if (timestamps_due.size() == 0) begin
            report_mismatch("unexpected result, matched", got.matched, 0);
         end else begin
            w = timestamps_due.pop_front();
            if (got.matched !== w.matched)
               report_mismatch("matched", got.matched, w.matched);
            if (got.consumed_len !== w.consumed_len)
               report_mismatch("consumed_len", got.consumed_len, w.consumed_len);
            if (got.month_num !== w.month_num)
               report_mismatch("month_num", got.month_num, w.month_num);
            if (got.day_num !== w.day_num)
               report_mismatch("day_num", got.day_num, w.day_num);
            if (got.year_num !== w.year_num)
               report_mismatch("year_num", got.year_num, w.year_num);
            if (got.hour_num !== w.hour_num)
               report_mismatch("hour_num", got.hour_num, w.hour_num);
            if (got.minute_num !== w.minute_num)
               report_mismatch("minute_num", got.minute_num, w.minute_num);
            if (got.second_num !== w.second_num)
               report_mismatch("second_num", got.second_num, w.second_num);
         end
         results_seen++;
         if (got.matched) matches_seen++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  timestamps_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      byte_queue_type txt;
      int      rand_bytes;
      int      rand_results;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.text_byte = '0;
      req_bus.last_byte = 1'b0;
      steady = 1'b0;
      clear_parser();

      add_row("Jan 1 0:0:0", 1'b1, stamp(11, 1, 1, 0, 0, 0, 0));
      add_row("dec 31 23:59:60:", 1'b1, stamp(16, 12, 31, 0, 23, 59, 60));
      add_row("FEB  9 2099 12:34:56", 1'b1, stamp(20, 2, 9, 2099, 12, 34, 56));
      add_row("Mar 5 1971 ::", 1'b0, NO_MATCH);
      add_row("aPr 10 1970:1:2", 1'b1, NO_MATCH);
      add_row("May 10 2100 1:2:3", 1'b1, NO_MATCH);
      add_row("jun 0 1:2:3", 1'b1, NO_MATCH);
      add_row("JUL 32 1:2:3", 1'b1, NO_MATCH);
      add_row("aug 3 24:0:0", 1'b1, NO_MATCH);
      add_row("Sep 3 1:60:0", 1'b1, NO_MATCH);
      add_row("Oct 3 1:2:61", 1'b1, NO_MATCH);
      add_row("Nov 7 1:2:99999", 1'b1, NO_MATCH);
      add_row("Jan ", 1'b1, NO_MATCH);
      add_row("Jan", 1'b1, NO_MATCH);
      add_row("J", 1'b1, NO_MATCH);
      add_row("Jxn 1 1:2:3", 1'b1, NO_MATCH);
      add_row("Jan 1 1:2", 1'b1, NO_MATCH);
      add_row("Jan 1 1971", 1'b1, NO_MATCH);
      add_row("Jan 99999 1:2:3", 1'b1, NO_MATCH);
      add_row("Dec 7 1:2:3 trailing text", 1'b0, NO_MATCH);
      add_row("Jan 00000000000000000007 1:2:3x", 1'b0, NO_MATCH);
      add_row("Jun 1 1:2:3\377\200", 1'b0, NO_MATCH);
      add_row("\312an 1 1:2:3", 1'b1, NO_MATCH);
      add_row("Aug  1 ::", 1'b0, NO_MATCH);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < dir_text.size(); i++) begin
         txt = {};
         put_text(txt, dir_text[i]);
         steady = (txt.size() > 100);
         send_text(txt, dir_typed[i], dir_want[i]);
      end
      steady = 1'b0;

      rand_bytes = bytes_sent;
      rand_results = results_seen + timestamps_due.size();
      while (bytes_sent - rand_bytes < RANDOM_BYTES
             || results_seen + timestamps_due.size() - rand_results < RANDOM_RESULTS) begin
         if ($urandom_range(0, 29) == 0) steady = !steady;
         random_string(txt);
         send_text(txt, 1'b0, NO_MATCH);
      end
      req_bus.valid <= 1'b0;
      steady = 1'b0;

      while (timestamps_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d strings in %0d bytes: directed timestamps and edge cases, then random",
               strings_sent, bytes_sent);
      $display("%0d results checked, %0d timestamps recognised, %0d mismatches",
               results_seen, matches_seen, errors);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/stp_pkg.sv
sv/stp_if.sv
sv/stp_front.sv
sv/stp_queue.sv
sv/stp_back.sv
sv/syslog_timestamp_parser_unit.sv
dv/tb_syslog_timestamp_parser_unit.sv
